/* rtl/modbus_register_poll_master_core_assert.svh */
// Assertion macros used by the poll master core RTL.
`ifndef MODBUS_REGISTER_POLL_MASTER_CORE_ASSERT_SVH
`define MODBUS_REGISTER_POLL_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define MBP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define MBP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mbpoll_pkg.sv */
// Types, constants and the CRC-16 byte update of the Modbus poll master.
package mbpoll_pkg;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_RX_BYTE = 2'd1,
		CMD_FAIL    = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_OK      = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_UART    = 3'd3,
		ST_FRAME   = 3'd4,
		ST_CRC     = 3'd5
	} status_t;

	typedef enum logic {
		REG_DEV_ADDR       = 1'b0,
		REG_START_REGISTER = 1'b1
	} cfg_reg_t;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_OUTCOME = 1'b1;

	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [7:0]  FUNC_READ  = 8'h03;
	localparam logic [7:0]  BYTE_COUNT = 8'h08;
	localparam logic [7:0]  REG_COUNT  = 8'h04;

	// Response frame positions.
	localparam logic [3:0] RESP_LEN      = 4'd13;
	localparam logic [3:0] RX_CRC_BYTES  = 4'd11;
	localparam logic [3:0] PAYLOAD_FIRST = 4'd3;
	localparam logic [3:0] PAYLOAD_LAST  = 4'd10;
	localparam logic [3:0] CRC_LOW_POS   = 4'd11;
	localparam logic [3:0] LAST_RX_POS   = 4'd12;

	typedef struct packed {
		logic active;
		logic [7:0] data;
		logic last;
	} req_beat_t;

	typedef struct packed {
		logic kind;
		logic [7:0] tx_byte;
		logic last;
		logic [2:0] status;
		logic [15:0] conductivity;
		logic signed [15:0] temperature;
		logic [15:0] dissolved_solids;
		logic [15:0] salinity;
		logic online;
		logic [31:0] good_polls;
		logic [31:0] bad_polls;
	} res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

/* rtl/mbpoll_ifs.sv */
// Valid/ready channel interfaces for commands in and results out.
interface mbpoll_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [7:0] rx_byte;
	logic fail_kind;

	modport source(output valid, cmd, rx_byte, fail_kind, input ready);
	modport sink(input valid, cmd, rx_byte, fail_kind, output ready);
endinterface

interface mbpoll_res_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] tx_byte;
	logic last;
	logic [2:0] status;
	logic [15:0] conductivity;
	logic signed [15:0] temperature;
	logic [15:0] dissolved_solids;
	logic [15:0] salinity;
	logic online;
	logic [31:0] good_polls;
	logic [31:0] bad_polls;

	modport source(output valid, kind, tx_byte, last, status, conductivity, temperature,
		dissolved_solids, salinity, online, good_polls, bad_polls, input ready);
	modport sink(input valid, kind, tx_byte, last, status, conductivity, temperature,
		dissolved_solids, salinity, online, good_polls, bad_polls, output ready);
endinterface

/* rtl/mbpoll_req_gen.sv */
// Request serialiser: emits the eight request bytes, folding the CRC in one byte a cycle while advance is high.
module mbpoll_req_gen (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [7:0]            dev_addr,
	input  logic [15:0]           start_register,
	input  logic                  advance,
	output mbpoll_pkg::req_beat_t beat
);
	import mbpoll_pkg::*;

	logic        active_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic [7:0]  addr_q;
	logic [15:0] reg_q;
	logic [7:0]  data;

	always_comb begin
		case (idx_q)
			3'd0: data = addr_q;
			3'd1: data = FUNC_READ;
			3'd2: data = reg_q[15:8];
			3'd3: data = reg_q[7:0];
			3'd4: data = 8'h00;
			3'd5: data = REG_COUNT;
			3'd6: data = crc_q[7:0];
			3'd7: data = crc_q[15:8];
			default: data = 8'h00;
		endcase
	end

	assign beat.active = active_q;
	assign beat.data   = data;
	assign beat.last   = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= 3'd0;
		end else if (start) begin
			active_q <= 1'b1;
			idx_q    <= 3'd0;
		end else if (active_q && advance) begin
			idx_q <= idx_q + 3'd1;
			if (idx_q == 3'd7)
				active_q <= 1'b0;
		end
	end

	// The CRC bytes go out after the six header bytes have been folded in.
	always_ff @(posedge clk) begin
		if (start) begin
			crc_q  <= CRC_INIT;
			addr_q <= dev_addr;
			reg_q  <= start_register;
		end else if (active_q && advance && idx_q < 3'd6) begin
			crc_q <= crc_byte(crc_q, data);
		end
	end

endmodule

/* rtl/modbus_register_poll_master_core.sv */
// Modbus RTU read-holding-registers poll master for a four-value sensor.
//
// Commands arrive on cmd_ch (start poll, received byte, transfer failure) and
// results leave on res_ch, both valid/ready; a beat moves when both are high.
// A start yields eight request beats (kind 0), the last one marked by last; the
// thirteenth response byte, or a failure during an exchange, yields one outcome
// beat (kind 1) with status, the four values, online and the two poll tallies.
// Other commands yield nothing. cfg_we writes device address (index 0) or start
// register (index 1) from cfg_wdata; write only while the block is idle.
// An outcome is loaded into the output register as its command leaves the input
// stage. Throughput while res_ch is ready: one received byte or failure per
// cycle outside a request burst; the request serialiser sends one byte per
// cycle, so a start holds the input stage for eight beats. When res_ch stalls
// the output register holds and the input stage fills, then cmd_ch.ready
// drops. Reset clears the exchange, tallies and values to zero, status to idle
// and the device address to 2; no clearing pass is needed.
`include "modbus_register_poll_master_core_assert.svh"

module modbus_register_poll_master_core (
	input  logic        clk,
	input  logic        arst_n,
	mbpoll_cmd_if.sink  cmd_ch,
	mbpoll_res_if.source res_ch,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata
);
	import mbpoll_pkg::*;

	// Configuration
	logic [7:0]  slave_addr_q;
	logic [15:0] start_reg_q;

	// Input stage
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] rx_s1;
	logic       fk_s1;

	// Exchange and result state
	logic        open_q;
	logic [3:0]  rx_cnt_q;
	logic [15:0] crc_q;
	logic        hdr_bad_q;
	logic [7:0]  crc_low_q;
	logic [7:0]  payload_q [8];
	logic [15:0] meas_q [4];
	status_t     status_q;
	logic        online_q;
	logic [31:0] good_q;
	logic [31:0] bad_q;

	// Output register
	logic out_valid_q;
	res_t res_q;

	req_beat_t req_beat;

	logic        can_load;
	logic        adv_s1;
	logic        req_start;
	logic        rx_take;
	logic        rx_end;
	logic        fail_end;
	logic        hdr_err;
	logic        crc_match;
	logic        success;
	logic        outcome;
	status_t     status_nxt;
	logic [15:0] crc_nxt;
	logic [3:0]  pl_off;
	logic [15:0] dec0, dec1, dec2, dec3;
	logic [31:0] good_nxt;
	logic [31:0] bad_nxt;

	assign can_load  = !out_valid_q || res_ch.ready;
	assign adv_s1    = valid_s1 && can_load && !req_beat.active;
	assign req_start = adv_s1 && (cmd_s1 == CMD_START);
	assign cmd_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd2;
			start_reg_q  <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DEV_ADDR:       slave_addr_q <= cfg_wdata[7:0];
				REG_START_REGISTER: start_reg_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd_ch.ready)
			valid_s1 <= cmd_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			cmd_s1 <= cmd_t'(cmd_ch.cmd);
			rx_s1  <= cmd_ch.rx_byte;
			fk_s1  <= cmd_ch.fail_kind;
		end
	end

	always_comb begin
		rx_take   = (cmd_s1 == CMD_RX_BYTE) && open_q && (rx_cnt_q < RESP_LEN);
		rx_end    = rx_take && (rx_cnt_q == LAST_RX_POS);
		fail_end  = (cmd_s1 == CMD_FAIL) && open_q;
		hdr_err   = (rx_cnt_q == 4'd0 && rx_s1 != slave_addr_q) ||
		            (rx_cnt_q == 4'd1 && rx_s1 != FUNC_READ) ||
		            (rx_cnt_q == 4'd2 && rx_s1 != BYTE_COUNT);
		crc_match = (crc_low_q == crc_q[7:0]) && (rx_s1 == crc_q[15:8]);
		success   = rx_end && !hdr_bad_q && crc_match;
		outcome   = rx_end || fail_end;
		crc_nxt   = crc_byte(crc_q, rx_s1);
		pl_off    = rx_cnt_q - PAYLOAD_FIRST;

		if (success)
			status_nxt = ST_OK;
		else if (rx_end && hdr_bad_q)
			status_nxt = ST_FRAME;
		else if (rx_end)
			status_nxt = ST_CRC;
		else if (fk_s1)
			status_nxt = ST_UART;
		else
			status_nxt = ST_TIMEOUT;

		// Register values are big-endian in the response.
		dec0 = {payload_q[0], payload_q[1]};
		dec1 = {payload_q[2], payload_q[3]};
		dec2 = {payload_q[4], payload_q[5]};
		dec3 = {payload_q[6], payload_q[7]};

		good_nxt = good_q + {31'd0, success};
		bad_nxt  = bad_q + {31'd0, !success};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			rx_cnt_q  <= 4'd0;
			crc_q     <= CRC_INIT;
			hdr_bad_q <= 1'b0;
			meas_q[0] <= 16'd0;
			meas_q[1] <= 16'd0;
			meas_q[2] <= 16'd0;
			meas_q[3] <= 16'd0;
			status_q  <= ST_IDLE;
			online_q  <= 1'b0;
			good_q    <= 32'd0;
			bad_q     <= 32'd0;
		end else if (adv_s1) begin
			case (cmd_s1)
				CMD_START: begin
					open_q    <= 1'b1;
					rx_cnt_q  <= 4'd0;
					crc_q     <= CRC_INIT;
					hdr_bad_q <= 1'b0;
				end
				CMD_RX_BYTE: begin
					if (rx_take) begin
						if (rx_cnt_q < RX_CRC_BYTES)
							crc_q <= crc_nxt;
						if (hdr_err)
							hdr_bad_q <= 1'b1;
						rx_cnt_q <= rx_cnt_q + 4'd1;
						if (rx_end)
							open_q <= 1'b0;
					end
				end
				CMD_FAIL: begin
					if (open_q)
						open_q <= 1'b0;
				end
				default: ;
			endcase
			if (outcome) begin
				status_q <= status_nxt;
				online_q <= success;
				good_q   <= good_nxt;
				bad_q    <= bad_nxt;
				if (success) begin
					meas_q[0] <= dec0;
					meas_q[1] <= dec1;
					meas_q[2] <= dec2;
					meas_q[3] <= dec3;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && rx_take) begin
			if (rx_cnt_q >= PAYLOAD_FIRST && rx_cnt_q <= PAYLOAD_LAST)
				payload_q[pl_off[2:0]] <= rx_s1;
			if (rx_cnt_q == CRC_LOW_POS)
				crc_low_q <= rx_s1;
		end
	end

	mbpoll_req_gen u_req_gen (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (req_start),
		.dev_addr       (slave_addr_q),
		.start_register (start_reg_q),
		.advance        (can_load),
		.beat           (req_beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (can_load)
			out_valid_q <= req_beat.active || (adv_s1 && outcome);
	end

	// The outcome beat shows the state as it stands after this item.
	always_ff @(posedge clk) begin
		if (can_load) begin
			if (req_beat.active) begin
				res_q.kind             <= KIND_REQUEST;
				res_q.tx_byte          <= req_beat.data;
				res_q.last             <= req_beat.last;
				res_q.status           <= ST_IDLE;
				res_q.conductivity     <= 16'd0;
				res_q.temperature      <= 16'd0;
				res_q.dissolved_solids <= 16'd0;
				res_q.salinity         <= 16'd0;
				res_q.online           <= 1'b0;
				res_q.good_polls       <= 32'd0;
				res_q.bad_polls        <= 32'd0;
			end else begin
				res_q.kind             <= KIND_OUTCOME;
				res_q.tx_byte          <= 8'h00;
				res_q.last             <= 1'b0;
				res_q.status           <= status_nxt;
				res_q.conductivity     <= success ? dec0 : meas_q[0];
				res_q.temperature      <= success ? dec1 : meas_q[1];
				res_q.dissolved_solids <= success ? dec2 : meas_q[2];
				res_q.salinity         <= success ? dec3 : meas_q[3];
				res_q.online           <= success;
				res_q.good_polls       <= good_nxt;
				res_q.bad_polls        <= bad_nxt;
			end
		end
	end

	assign res_ch.valid            = out_valid_q;
	assign res_ch.kind             = res_q.kind;
	assign res_ch.tx_byte          = res_q.tx_byte;
	assign res_ch.last             = res_q.last;
	assign res_ch.status           = res_q.status;
	assign res_ch.conductivity     = res_q.conductivity;
	assign res_ch.temperature      = res_q.temperature;
	assign res_ch.dissolved_solids = res_q.dissolved_solids;
	assign res_ch.salinity         = res_q.salinity;
	assign res_ch.online           = res_q.online;
	assign res_ch.good_polls       = res_q.good_polls;
	assign res_ch.bad_polls        = res_q.bad_polls;

	`MBP_ASSERT_IMP(a_hold_during_burst, req_beat.active, !adv_s1, "command taken during request burst")
	`MBP_ASSERT_IMP(a_burst_runs_on, out_valid_q && res_q.kind == KIND_REQUEST && !res_q.last, req_beat.active, "request burst ended early")
	`MBP_ASSERT_NXT(a_one_tally_step, adv_s1 && outcome, (good_q + bad_q) == ($past(good_q + bad_q) + 32'd1), "outcome did not count exactly one poll")
	`MBP_ASSERT_IMP(a_count_bound, 1'b1, rx_cnt_q <= RESP_LEN, "receive count beyond frame length")

endmodule
